@@ hw/rtl/sector_cache_clock_policy_unit_macros.svh @@
// Assertion macros shared by the sector cache clock policy RTL.
`ifndef SECTOR_CACHE_CLOCK_POLICY_UNIT_MACROS_SVH
`define SECTOR_CACHE_CLOCK_POLICY_UNIT_MACROS_SVH

// Same-cycle implication, checked at every clk edge outside reset.
`define SCC_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked at every clk edge outside reset.
`define SCC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ hw/rtl/scc_pkg.sv @@
// Shared types and codes of the sector cache clock policy unit.
`default_nettype none

package scc_pkg;

	typedef logic [31:0] sector_t;
	typedef logic [5:0]  slot_t;
	typedef logic [1:0]  kind_t;

	localparam logic  ACT_ACCESS = 1'b0;
	localparam logic  ACT_FLUSH  = 1'b1;

	localparam kind_t KIND_MAIN       = 2'd0;
	localparam kind_t KIND_AHEAD      = 2'd1;
	localparam kind_t KIND_FLUSH_WB   = 2'd2;
	localparam kind_t KIND_FLUSH_NONE = 2'd3;

	typedef struct packed {
		logic    action;
		sector_t sector;
		logic    mark_dirty;
		logic    read_ahead;
	} item_t;

	typedef struct packed {
		kind_t   kind;
		logic    hit;
		slot_t   slot;
		logic    fetch;
		sector_t fetch_sector;
		logic    writeback;
		sector_t writeback_sector;
		logic    is_last;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_VICTIM,
		ST_FLUSH
	} state_t;

	// Memory port control: read enable, write enable, and the flag bits to write.
	typedef struct packed {
		logic rd;
		logic wr;
		logic acc;
		logic dirty;
	} mem_cmd_t;

	// Flags of the entry read in the previous cycle, and its tag compare.
	typedef struct packed {
		logic accessed;
		logic dirty;
		logic match;
	} mem_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/scc_store.sv @@
// Slot memory of tag, accessed and dirty bits, with registered read and tag compare.
`default_nettype none

module scc_store #(
	parameter int NUM_SLOTS   = 64,
	parameter int SECTOR_BITS = 32,
	localparam int IDXW  = $clog2(NUM_SLOTS),
	localparam int WORDW = SECTOR_BITS + 2
) (
	input  wire                     clk,
	input  scc_pkg::mem_cmd_t       cmd,
	input  wire  [IDXW-1:0]         rd_addr,
	input  wire  [IDXW-1:0]         wr_addr,
	input  wire  [SECTOR_BITS-1:0]  wr_tag,
	input  wire  [SECTOR_BITS-1:0]  key,
	output logic [SECTOR_BITS-1:0]  rd_tag,
	output scc_pkg::mem_stat_t      stat
);

	logic [WORDW-1:0] mem [NUM_SLOTS];
	logic [WORDW-1:0] rd_q;

	// Read before write on the same edge; the sequencer never needs the new word early.
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= {wr_tag, cmd.acc, cmd.dirty};
		end
		if (cmd.rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_tag        = rd_q[WORDW-1:2];
	assign stat.accessed = rd_q[1];
	assign stat.dirty    = rd_q[0];
	assign stat.match    = (rd_q[WORDW-1:2] == key);

endmodule

`default_nettype wire

@@ hw/rtl/sector_cache_clock_policy_unit.sv @@
// Top level of the sector cache clock policy unit: a fully associative tag store of
// NUM_SLOTS slots with second-chance (clock) replacement. Start an operation by raising
// start while busy is low; the word on item is taken at that edge. An access word yields
// one result, or two with read_ahead set (the second for sector + 1, wrapping modulo
// 2**SECTOR_BITS). A flush word yields one result per dirty slot in slot order, or a
// single "nothing dirty" result, and leaves the store empty. Each result sits on result
// for one cycle with result_strobe high; there is no way to hold it off, so sample it
// then. is_last marks the final result of the word. All slot state lives in one memory
// (one read port and one write port, registered read), and every operation is a linear
// scan of it: a lookup reads one slot per cycle until a hit or the fill count.
// A miss on a full store then walks the clock hand from slot 0, clearing accessed bits
// until it meets a slot whose accessed bit is already clear. A read-ahead repeats the
// whole sequence for the next sector. busy drops with the final result, and the next
// word may be accepted in that same cycle. Reset needs no clearing pass: the fill count
// alone decides which slots hold data.
`default_nettype none
`include "sector_cache_clock_policy_unit_macros.svh"

module sector_cache_clock_policy_unit #(
	parameter int NUM_SLOTS   = 64,
	parameter int SECTOR_BITS = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  scc_pkg::item_t     item,
	output logic               busy,
	output scc_pkg::result_t   result,
	output logic               result_strobe
);

	localparam int IDXW = $clog2(NUM_SLOTS);
	localparam int CW   = $clog2(NUM_SLOTS + 1);
	localparam logic [CW-1:0]   SLOTS_C  = CW'(NUM_SLOTS);
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_SLOTS - 1);

	typedef logic [SECTOR_BITS-1:0] tag_t;

	// Control state.
	scc_pkg::state_t state_q, state_d;
	logic [CW-1:0]   ctr_q, ctr_d;      // next slot to read
	logic [CW-1:0]   fill_q, fill_d;    // filled slots, 0 .. NUM_SLOTS
	logic            pass_q, pass_d;    // working on the read-ahead access
	logic            ahead_q, ahead_d;  // read-ahead requested
	logic            pend_q, pend_d;    // flush: a dirty slot waits to be reported
	logic            strobe_q, strobe_d;
	logic            v_s1;              // read data of idx_s1 is valid this cycle

	// Payload.
	tag_t               sec_q, sec_d;
	logic               mdirty_q, mdirty_d;
	logic [IDXW-1:0]    idx_s1;
	logic [IDXW-1:0]    pend_slot_q, pend_slot_d;
	tag_t               pend_tag_q, pend_tag_d;
	scc_pkg::result_t   res_q, res_d;

	// Memory port.
	scc_pkg::mem_cmd_t  cmd;
	scc_pkg::mem_stat_t stat;
	logic [IDXW-1:0]    wr_addr;
	tag_t               wr_tag;
	tag_t               rd_tag;

	logic issue;
	logic scan_done;
	logic can_issue;
	logic more;

	scc_store #(
		.NUM_SLOTS   (NUM_SLOTS),
		.SECTOR_BITS (SECTOR_BITS)
	) u_store (
		.clk     (clk),
		.cmd     (cmd),
		.rd_addr (ctr_q[IDXW-1:0]),
		.wr_addr (wr_addr),
		.wr_tag  (wr_tag),
		.key     (sec_q),
		.rd_tag  (rd_tag),
		.stat    (stat)
	);

	// Every slot below the fill count has been read and compared.
	assign scan_done = (ctr_q == fill_q) && !v_s1;
	assign can_issue = (ctr_q < fill_q);
	// A read-ahead access still follows the current one.
	assign more      = ahead_q && !pass_q;

	always_comb begin
		state_d     = state_q;
		ctr_d       = ctr_q;
		fill_d      = fill_q;
		pass_d      = pass_q;
		ahead_d     = ahead_q;
		pend_d      = pend_q;
		sec_d       = sec_q;
		mdirty_d    = mdirty_q;
		pend_slot_d = pend_slot_q;
		pend_tag_d  = pend_tag_q;
		res_d       = res_q;
		strobe_d    = 1'b0;
		issue       = 1'b0;
		cmd         = '0;
		wr_addr     = idx_s1;
		wr_tag      = sec_q;

		case (state_q)
			scc_pkg::ST_IDLE: begin
				if (start) begin
					sec_d    = tag_t'(item.sector);
					mdirty_d = item.mark_dirty;
					ahead_d  = item.read_ahead;
					pass_d   = 1'b0;
					pend_d   = 1'b0;
					ctr_d    = '0;
					state_d  = (item.action == scc_pkg::ACT_FLUSH) ?
						scc_pkg::ST_FLUSH : scc_pkg::ST_LOOKUP;
				end
			end

			scc_pkg::ST_LOOKUP: begin
				if (v_s1 && stat.match) begin
					// Hit: set accessed, OR in the dirty request.
					cmd.wr    = 1'b1;
					cmd.acc   = 1'b1;
					cmd.dirty = stat.dirty | mdirty_q;
					wr_addr   = idx_s1;
					res_d     = '0;
					res_d.kind    = pass_q ? scc_pkg::KIND_AHEAD : scc_pkg::KIND_MAIN;
					res_d.hit     = 1'b1;
					res_d.slot    = scc_pkg::slot_t'(idx_s1);
					res_d.is_last = !more;
					strobe_d      = 1'b1;
				end else if (scan_done) begin
					if (fill_q != SLOTS_C) begin
						// Miss with room: take the next free slot.
						cmd.wr    = 1'b1;
						cmd.acc   = 1'b1;
						cmd.dirty = mdirty_q;
						wr_addr   = fill_q[IDXW-1:0];
						fill_d    = fill_q + 1'b1;
						res_d     = '0;
						res_d.kind         = pass_q ? scc_pkg::KIND_AHEAD : scc_pkg::KIND_MAIN;
						res_d.slot         = scc_pkg::slot_t'(fill_q[IDXW-1:0]);
						res_d.fetch        = 1'b1;
						res_d.fetch_sector = scc_pkg::sector_t'(sec_q);
						res_d.is_last      = !more;
						strobe_d           = 1'b1;
					end else begin
						// Full: start the clock hand at slot 0.
						ctr_d   = '0;
						state_d = scc_pkg::ST_VICTIM;
					end
				end else if (can_issue) begin
					issue = 1'b1;
					ctr_d = ctr_q + 1'b1;
				end
			end

			scc_pkg::ST_VICTIM: begin
				if (v_s1 && !stat.accessed) begin
					// Victim found: replace, report its old dirty contents.
					cmd.wr    = 1'b1;
					cmd.acc   = 1'b1;
					cmd.dirty = mdirty_q;
					wr_addr   = idx_s1;
					res_d     = '0;
					res_d.kind             = pass_q ? scc_pkg::KIND_AHEAD : scc_pkg::KIND_MAIN;
					res_d.slot             = scc_pkg::slot_t'(idx_s1);
					res_d.fetch            = 1'b1;
					res_d.fetch_sector     = scc_pkg::sector_t'(sec_q);
					res_d.writeback        = stat.dirty;
					res_d.writeback_sector = stat.dirty ? scc_pkg::sector_t'(rd_tag) : '0;
					res_d.is_last          = !more;
					strobe_d               = 1'b1;
				end else begin
					if (v_s1) begin
						// Second chance: drop the accessed bit, keep tag and dirty.
						cmd.wr    = 1'b1;
						cmd.acc   = 1'b0;
						cmd.dirty = stat.dirty;
						wr_addr   = idx_s1;
						wr_tag    = rd_tag;
					end
					issue = 1'b1;
					ctr_d = (ctr_q[IDXW-1:0] == LAST_IDX) ? '0 : ctr_q + 1'b1;
				end
			end

			scc_pkg::ST_FLUSH: begin
				if (can_issue) begin
					issue = 1'b1;
					ctr_d = ctr_q + 1'b1;
				end
				if (v_s1 && stat.dirty) begin
					// Report the held dirty slot now that a later one exists.
					if (pend_q) begin
						res_d = '0;
						res_d.kind             = scc_pkg::KIND_FLUSH_WB;
						res_d.slot             = scc_pkg::slot_t'(pend_slot_q);
						res_d.writeback        = 1'b1;
						res_d.writeback_sector = scc_pkg::sector_t'(pend_tag_q);
						strobe_d               = 1'b1;
					end
					pend_d      = 1'b1;
					pend_slot_d = idx_s1;
					pend_tag_d  = rd_tag;
				end
				if (scan_done) begin
					res_d = '0;
					if (pend_q) begin
						res_d.kind             = scc_pkg::KIND_FLUSH_WB;
						res_d.slot             = scc_pkg::slot_t'(pend_slot_q);
						res_d.writeback        = 1'b1;
						res_d.writeback_sector = scc_pkg::sector_t'(pend_tag_q);
					end else begin
						res_d.kind = scc_pkg::KIND_FLUSH_NONE;
					end
					res_d.is_last = 1'b1;
					strobe_d      = 1'b1;
					pend_d        = 1'b0;
					fill_d        = '0;
					state_d       = scc_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = scc_pkg::ST_IDLE;
			end
		endcase

		// After an access result: advance to the read-ahead sector or go idle.
		if (strobe_d && (state_q == scc_pkg::ST_LOOKUP || state_q == scc_pkg::ST_VICTIM)) begin
			if (more) begin
				pass_d  = 1'b1;
				sec_d   = sec_q + 1'b1;
				ctr_d   = '0;
				state_d = scc_pkg::ST_LOOKUP;
			end else begin
				state_d = scc_pkg::ST_IDLE;
			end
		end

		cmd.rd = issue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= scc_pkg::ST_IDLE;
			ctr_q    <= '0;
			fill_q   <= '0;
			pass_q   <= 1'b0;
			ahead_q  <= 1'b0;
			pend_q   <= 1'b0;
			strobe_q <= 1'b0;
			v_s1     <= 1'b0;
		end else begin
			state_q  <= state_d;
			ctr_q    <= ctr_d;
			fill_q   <= fill_d;
			pass_q   <= pass_d;
			ahead_q  <= ahead_d;
			pend_q   <= pend_d;
			strobe_q <= strobe_d;
			v_s1     <= issue;
		end
	end

	always_ff @(posedge clk) begin
		sec_q       <= sec_d;
		mdirty_q    <= mdirty_d;
		pend_slot_q <= pend_slot_d;
		pend_tag_q  <= pend_tag_d;
		res_q       <= res_d;
		if (issue) begin
			idx_s1 <= ctr_q[IDXW-1:0];
		end
	end

	assign busy          = (state_q != scc_pkg::ST_IDLE);
	assign result        = res_q;
	assign result_strobe = strobe_q;

	`SCC_ASSERT_NOW(a_fill_in_range, 1'b1, fill_q <= SLOTS_C, "fill count beyond slot count")
	`SCC_ASSERT_NEXT(a_idle_quiet, !busy, !result_strobe, "result word while idle")
	`SCC_ASSERT_NOW(a_flush_empties, result_strobe && result.is_last && (result.kind == scc_pkg::KIND_FLUSH_WB || result.kind == scc_pkg::KIND_FLUSH_NONE), fill_q == '0, "store not empty after flush")
	`SCC_ASSERT_NOW(a_read_in_scan, v_s1, state_q != scc_pkg::ST_IDLE, "read data pending while idle")

endmodule

`default_nettype wire
